### rtl/fw2_pkg.sv
package fw2_pkg;

  // Coordinates inside the block: wide enough for a corner one past the
  // largest 11-bit bound and for a Fenwick index that steps past the grid.
  localparam int unsigned CoordW = 13;
  localparam int unsigned FieldW = 11;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    REQ_RECT_ADD  = 2'd0,
    REQ_POINT_ADD = 2'd1,
    REQ_QUERY     = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_RESERVED  = 2'd3
  } status_e;

endpackage

### rtl/fenwick_2d_sparse_range_add.sv
// Sparse 2D Fenwick tree: rectangle add, point add and point query.
// Input items arrive on the s_axis channel and each produces exactly one
// result item on the m_axis channel (point value and status). A write on
// cfg_we_i/cfg_wdata_i sets grid_size; write it only while the block is idle.
// One sequencer drives a single 64-bit adder and the node memories. A node
// visit on an add is a read, then a read-modify-write; a freshly allocated
// node skips the read. A query visit reads the node, then steps down, and
// adds a left sibling sum in an extra Q_LEFT step when it goes right past a
// left child. The work per item grows with the corners, rows and levels
// it visits; rows and levels grow with log2 of grid_size.
// After reset the row root table is cleared, entries 0 to MAX_GRID, during
// which s_axis_tready stays low. The block accepts one item at a time and
// can take the next item while the previous result waits in the output
// register; if the receiver stalls, the finished item waits in turn until
// that register is free.
module fenwick_2d_sparse_range_add
  import fw2_pkg::*;
#(
  parameter int unsigned MAX_GRID  = 1024,
  parameter int unsigned NODE_POOL = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FieldW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // req_type[1:0], row_low[12:2], col_low[23:13], row_high[34:24],
  // col_high[45:35], delta[77:46], zero pad[79:78]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // point_value[63:0], status[65:64], zero pad[71:66]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned RowW  = $clog2(MAX_GRID + 1);
  localparam int unsigned NodeW = $clog2(NODE_POOL);
  localparam logic [NodeW-1:0] LastNode = NodeW'(NODE_POOL - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(MAX_GRID);

  typedef enum logic [3:0] {
    CLEAR, IDLE, CORNER, ROOT_RD, ROOT_CHK, NODE_RD, UPD,
    Q_ROOT_RD, Q_ROOT_CHK, Q_NODE_RD, Q_NODE, Q_LEFT, FINISH
  } state_e;

  // Memories
  logic [SumW-1:0]  sum_mem [NODE_POOL];
  logic [NodeW-1:0] lft_mem [NODE_POOL];
  logic [NodeW-1:0] rgt_mem [NODE_POOL];
  logic [NodeW-1:0] root_mem [MAX_GRID + 1];

  logic [SumW-1:0]  sum_rd_q;
  logic [NodeW-1:0] lft_rd_q, rgt_rd_q, root_rd_q;
  logic [NodeW-1:0] nd_raddr, nd_waddr;
  logic             nd_we;
  logic [SumW-1:0]  nd_sum_w;
  logic [NodeW-1:0] nd_lft_w, nd_rgt_w;
  logic             rt_we;
  logic [RowW-1:0]  rt_waddr, rt_raddr;
  logic [NodeW-1:0] rt_wdata;

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      sum_mem[nd_waddr] <= nd_sum_w;
      lft_mem[nd_waddr] <= nd_lft_w;
      rgt_mem[nd_waddr] <= nd_rgt_w;
    end
    sum_rd_q <= sum_mem[nd_raddr];
    lft_rd_q <= lft_mem[nd_raddr];
    rgt_rd_q <= rgt_mem[nd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      root_mem[rt_waddr] <= rt_wdata;
    end
    root_rd_q <= root_mem[rt_raddr];
  end

  // Registers
  state_e            state_q, state_d;
  logic [RowW-1:0]   clr_q, clr_d;
  logic [FieldW-1:0] grid_q;
  logic [NodeW-1:0]  nf_q, nf_d;
  logic              exh_q, exh_d;
  logic              empty_q, empty_d;
  req_type_e         kind_q, kind_d;
  logic [CoordW-1:0] n_q, n_d, r1_q, r1_d, c1_q, c1_d, r2p_q, r2p_d, c2p_q, c2p_d;
  logic [CoordW-1:0] i_q, i_d, col_q, col_d, lo_q, lo_d, hi_q, hi_d;
  logic [1:0]        corner_q, corner_d;
  logic [SumW-1:0]   d_q, d_d, v_q, v_d, acc_q, acc_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic              fresh_q, fresh_d;
  logic              out_valid_q, out_valid_d;
  logic [SumW-1:0]   out_val_q, out_val_d;
  status_e           out_st_q, out_st_d;

  // Fields of the incoming item
  req_type_e         in_kind;
  logic [FieldW-1:0] in_r1, in_c1, in_r2, in_c2;
  logic [DeltaW-1:0] in_delta;
  assign in_kind  = req_type_e'(s_axis_tdata[1:0]);
  assign in_r1    = s_axis_tdata[12:2];
  assign in_c1    = s_axis_tdata[23:13];
  assign in_r2    = s_axis_tdata[34:24];
  assign in_c2    = s_axis_tdata[45:35];
  assign in_delta = s_axis_tdata[77:46];

  // A rectangle's low bounds of zero are raised to one before the empty check.
  logic [FieldW-1:0] in_r1_lo, in_c1_lo;
  assign in_r1_lo = (in_r1 == '0) ? FieldW'(1) : in_r1;
  assign in_c1_lo = (in_c1 == '0) ? FieldW'(1) : in_c1;

  logic [CoordW-1:0] eff_n;
  always_comb begin
    if (grid_q == '0) begin
      eff_n = CoordW'(1);
    end else if (32'(grid_q) > MAX_GRID) begin
      eff_n = CoordW'(MAX_GRID);
    end else begin
      eff_n = CoordW'(grid_q);
    end
  end

  // The shared adder
  logic [SumW-1:0]  add_a, add_b, add_y;
  logic [SumW-1:0]  sum_in;
  logic [NodeW-1:0] lft_in, rgt_in;
  assign sum_in = fresh_q ? '0 : sum_rd_q;
  assign lft_in = fresh_q ? '0 : lft_rd_q;
  assign rgt_in = fresh_q ? '0 : rgt_rd_q;
  assign add_a  = (state_q == UPD) ? sum_in : acc_q;
  assign add_b  = (state_q == UPD) ? v_q : sum_rd_q;
  assign add_y  = add_a + add_b;

  logic [CoordW-1:0] lowbit, i_up, i_dn, mid, lo_hi;
  assign lowbit = i_q & (~i_q + CoordW'(1));
  assign i_up   = i_q + lowbit;
  assign i_dn   = i_q - lowbit;
  assign lo_hi  = lo_q + hi_q;
  assign mid    = lo_hi >> 1;

  logic              pool_full;
  assign pool_full = (nf_q >= LastNode);

  logic [CoordW-1:0] cr_row, cr_col;
  logic              last_corner;
  logic [NodeW-1:0]  child;
  logic              go_left;
  logic              load_out;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    nf_d     = nf_q;
    exh_d    = exh_q;
    empty_d  = empty_q;
    kind_d   = kind_q;
    n_d      = n_q;
    r1_d     = r1_q;
    c1_d     = c1_q;
    r2p_d    = r2p_q;
    c2p_d    = c2p_q;
    i_d      = i_q;
    col_d    = col_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    corner_d = corner_q;
    d_d      = d_q;
    v_d      = v_q;
    acc_d    = acc_q;
    node_d   = node_q;
    fresh_d  = fresh_q;
    nd_raddr = node_q;
    nd_waddr = node_q;
    nd_we    = 1'b0;
    nd_sum_w = add_y;
    nd_lft_w = lft_in;
    nd_rgt_w = rgt_in;
    rt_we    = 1'b0;
    rt_waddr = RowW'(i_q);
    rt_raddr = RowW'(i_q);
    rt_wdata = nf_q + NodeW'(1);
    load_out = 1'b0;
    cr_row   = r1_q;
    cr_col   = c1_q;
    child    = '0;
    go_left  = 1'b0;
    last_corner = (kind_q != REQ_RECT_ADD) || (corner_q == 2'd3);
    s_axis_tready = (state_q == IDLE);

    unique case (state_q)
      CLEAR: begin
        rt_we    = 1'b1;
        rt_waddr = clr_q;
        rt_wdata = '0;
        clr_d    = clr_q + RowW'(1);
        if (clr_q == LastRow) begin
          state_d = IDLE;
        end
      end
      IDLE: begin
        if (s_axis_tvalid) begin
          kind_d   = in_kind;
          n_d      = eff_n;
          acc_d    = '0;
          empty_d  = 1'b0;
          corner_d = '0;
          d_d      = {{(SumW-DeltaW){in_delta[DeltaW-1]}}, in_delta};
          r1_d     = CoordW'(in_r1);
          c1_d     = CoordW'(in_c1);
          r2p_d    = CoordW'(in_r2) + CoordW'(1);
          c2p_d    = CoordW'(in_c2) + CoordW'(1);
          state_d  = FINISH;
          unique case (in_kind)
            REQ_RECT_ADD: begin
              r1_d = CoordW'(in_r1_lo);
              c1_d = CoordW'(in_c1_lo);
              if ((in_r1_lo > in_r2) || (in_c1_lo > in_c2)) begin
                empty_d = 1'b1;
              end else if (!exh_q) begin
                state_d = CORNER;
              end
            end
            REQ_POINT_ADD: begin
              if (!exh_q) state_d = CORNER;
            end
            REQ_QUERY: begin
              if (CoordW'(in_r1) > eff_n) r1_d = eff_n;
              if (CoordW'(in_c1) > eff_n) c1_d = eff_n;
              i_d   = (CoordW'(in_r1) > eff_n) ? eff_n : CoordW'(in_r1);
              col_d = (CoordW'(in_c1) > eff_n) ? eff_n : CoordW'(in_c1);
              if ((in_r1 != '0) && (in_c1 != '0)) state_d = Q_ROOT_RD;
            end
            default: state_d = FINISH;
          endcase
        end
      end
      CORNER: begin
        // Corners in order: (r1,c1,+d), (r2+1,c1,-d), (r2+1,c2+1,+d), (r1,c2+1,-d).
        unique case (corner_q)
          2'd0: begin cr_row = r1_q;  cr_col = c1_q;  end
          2'd1: begin cr_row = r2p_q; cr_col = c1_q;  end
          2'd2: begin cr_row = r2p_q; cr_col = c2p_q; end
          default: begin cr_row = r1_q; cr_col = c2p_q; end
        endcase
        v_d   = corner_q[0] ? (SumW'(0) - d_q) : d_q;
        i_d   = cr_row;
        col_d = cr_col;
        if ((cr_row == '0) || (cr_row > n_q) || (cr_col == '0) || (cr_col > n_q)) begin
          corner_d = corner_q + 2'd1;
          if (last_corner) state_d = FINISH;
        end else begin
          state_d = ROOT_RD;
        end
      end
      ROOT_RD: begin
        lo_d    = CoordW'(1);
        hi_d    = n_q;
        state_d = ROOT_CHK;
      end
      ROOT_CHK: begin
        if (root_rd_q == '0) begin
          if (pool_full) begin
            exh_d   = 1'b1;
            state_d = FINISH;
          end else begin
            rt_we   = 1'b1;
            nf_d    = nf_q + NodeW'(1);
            node_d  = nf_q + NodeW'(1);
            fresh_d = 1'b1;
            state_d = UPD;
          end
        end else begin
          node_d  = root_rd_q;
          state_d = NODE_RD;
        end
      end
      NODE_RD: begin
        fresh_d = 1'b0;
        state_d = UPD;
      end
      UPD: begin
        nd_we = 1'b1;
        if (lo_q >= hi_q) begin
          i_d = i_up;
          if (i_up > n_q) begin
            corner_d = corner_q + 2'd1;
            state_d  = last_corner ? FINISH : CORNER;
          end else begin
            state_d = ROOT_RD;
          end
        end else begin
          go_left = (col_q <= mid);
          child   = go_left ? lft_in : rgt_in;
          if (go_left) hi_d = mid;
          else         lo_d = mid + CoordW'(1);
          if (child == '0) begin
            if (pool_full) begin
              exh_d   = 1'b1;
              state_d = FINISH;
            end else begin
              nf_d    = nf_q + NodeW'(1);
              node_d  = nf_q + NodeW'(1);
              fresh_d = 1'b1;
              if (go_left) nd_lft_w = nf_q + NodeW'(1);
              else         nd_rgt_w = nf_q + NodeW'(1);
            end
          end else begin
            node_d  = child;
            state_d = NODE_RD;
          end
        end
      end
      Q_ROOT_RD: begin
        lo_d    = CoordW'(1);
        hi_d    = n_q;
        state_d = Q_ROOT_CHK;
      end
      Q_ROOT_CHK: begin
        if (root_rd_q == '0) begin
          i_d     = i_dn;
          state_d = (i_dn == '0) ? FINISH : Q_ROOT_RD;
        end else begin
          node_d  = root_rd_q;
          state_d = Q_NODE_RD;
        end
      end
      Q_NODE_RD: begin
        state_d = Q_NODE;
      end
      Q_NODE: begin
        // Present the left child so its sum is ready in Q_LEFT.
        nd_raddr = lft_rd_q;
        if (col_q >= hi_q) begin
          acc_d   = add_y;
          i_d     = i_dn;
          state_d = (i_dn == '0) ? FINISH : Q_ROOT_RD;
        end else if (col_q <= mid) begin
          hi_d   = mid;
          node_d = lft_rd_q;
          if (lft_rd_q == '0) begin
            i_d     = i_dn;
            state_d = (i_dn == '0) ? FINISH : Q_ROOT_RD;
          end else begin
            state_d = Q_NODE_RD;
          end
        end else begin
          lo_d   = mid + CoordW'(1);
          node_d = rgt_rd_q;
          if (lft_rd_q != '0) begin
            state_d = Q_LEFT;
          end else if (rgt_rd_q == '0) begin
            i_d     = i_dn;
            state_d = (i_dn == '0) ? FINISH : Q_ROOT_RD;
          end else begin
            state_d = Q_NODE_RD;
          end
        end
      end
      Q_LEFT: begin
        acc_d = add_y;
        if (node_q == '0) begin
          i_d     = i_dn;
          state_d = (i_dn == '0) ? FINISH : Q_ROOT_RD;
        end else begin
          state_d = Q_NODE_RD;
        end
      end
      FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_val_d   = acc_q;
      out_st_d    = exh_q ? ST_EXHAUSTED : (empty_q ? ST_EMPTY : ST_DONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CLEAR;
      clr_q       <= '0;
      grid_q      <= FieldW'(1024);
      nf_q        <= '0;
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nf_q        <= nf_d;
      exh_q       <= exh_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    empty_q   <= empty_d;
    kind_q    <= kind_d;
    n_q       <= n_d;
    r1_q      <= r1_d;
    c1_q      <= c1_d;
    r2p_q     <= r2p_d;
    c2p_q     <= c2p_d;
    i_q       <= i_d;
    col_q     <= col_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    corner_q  <= corner_d;
    d_q       <= d_d;
    v_q       <= v_d;
    acc_q     <= acc_d;
    node_q    <= node_d;
    fresh_q   <= fresh_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_st_q, out_val_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) nf_q >= $past(nf_q))
    else $error("node allocation pointer moved backward");
  assert property (@(posedge clk_i) disable iff (!rst_ni) exh_q |=> exh_q)
    else $error("pool exhaustion flag cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && exh_q) |=> (out_st_q == ST_EXHAUSTED))
    else $error("exhausted pool not reported");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CLEAR) |-> !s_axis_tready)
    else $error("item accepted during root clearing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("stalled result dropped");

endmodule

### tb/sv/tb_fenwick_2d_sparse_range_add.sv
module tb_fenwick_2d_sparse_range_add;
  import fw2_pkg::*;

  localparam int unsigned GridMax  = 1024;
  localparam int unsigned PoolSize = 65536;

  typedef struct packed {
    req_type_e   kind;
    logic [10:0] r1;
    logic [10:0] c1;
    logic [10:0] r2;
    logic [10:0] c2;
    logic [31:0] d;
  } fw_req_t;

  typedef struct packed {
    logic [63:0] val;
    status_e     st;
  } fw_res_t;

  typedef struct packed {
    fw_req_t req;
    logic    fixed;
    fw_res_t res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [FieldW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  fenwick_2d_sparse_range_add #(.MAX_GRID(GridMax), .NODE_POOL(PoolSize)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the block's state.
  bit [10:0] grid_cfg;
  bit [15:0] slot_root [0:GridMax];
  bit [63:0] tree_sum [PoolSize];
  bit [15:0] tree_left [PoolSize];
  bit [15:0] tree_right [PoolSize];
  int unsigned nodes_used;
  bit pool_dry;

  fw_res_t pending_results[$];
  int unsigned items_sent, results_seen, mismatches;
  int unsigned n_adds, n_queries, n_empty, n_dry;
  bit quiet, hold_done;

  function automatic int unsigned span();
    int unsigned g;
    g = grid_cfg;
    if (g == 0) g = 1;
    if (g > GridMax) g = GridMax;
    return g;
  endfunction

  function automatic int unsigned grab_node();
    if (nodes_used >= PoolSize - 1) begin
      pool_dry = 1'b1;
      return 0;
    end
    nodes_used++;
    tree_sum[nodes_used] = '0;
    tree_left[nodes_used] = '0;
    tree_right[nodes_used] = '0;
    return nodes_used;
  endfunction

  function automatic void column_update(int unsigned row, int unsigned col, int unsigned n,
                                        bit [63:0] v);
    int unsigned lo, hi, nd, mid, ch;
    lo = 1;
    hi = n;
    nd = slot_root[row];
    if (nd == 0) begin
      nd = grab_node();
      if (nd == 0) return;
      slot_root[row] = nd;
    end
    forever begin
      tree_sum[nd] += v;
      if (lo >= hi) return;
      mid = (lo + hi) >> 1;
      if (col <= mid) begin
        ch = tree_left[nd];
        if (ch == 0) begin
          ch = grab_node();
          if (ch == 0) return;
          tree_left[nd] = ch;
        end
        hi = mid;
      end else begin
        ch = tree_right[nd];
        if (ch == 0) begin
          ch = grab_node();
          if (ch == 0) return;
          tree_right[nd] = ch;
        end
        lo = mid + 1;
      end
      nd = ch;
    end
  endfunction

  function automatic bit [63:0] column_sum(int unsigned nd, int unsigned col, int unsigned n);
    int unsigned lo, hi, mid;
    bit [63:0] acc;
    lo = 1;
    hi = n;
    acc = '0;
    while (nd != 0) begin
      if (col >= hi) begin
        acc += tree_sum[nd];
        break;
      end
      mid = (lo + hi) >> 1;
      if (col <= mid) begin
        nd = tree_left[nd];
        hi = mid;
      end else begin
        if (tree_left[nd] != 0) acc += tree_sum[tree_left[nd]];
        nd = tree_right[nd];
        lo = mid + 1;
      end
    end
    return acc;
  endfunction

  function automatic void corner_update(int unsigned row, int unsigned col, bit [63:0] v);
    int unsigned n, i;
    n = span();
    if (row == 0 || row > n || col == 0 || col > n) return;
    for (i = row; i <= n; i += i & (~i + 1)) begin
      if (pool_dry) return;
      column_update(i, col, n, v);
    end
  endfunction

  function automatic bit [63:0] prefix_value(int unsigned row, int unsigned col);
    int unsigned n, i;
    bit [63:0] acc;
    n = span();
    acc = '0;
    if (row > n) row = n;
    if (col > n) col = n;
    if (row == 0 || col == 0) return acc;
    for (i = row; i > 0; i -= i & (~i + 1)) acc += column_sum(slot_root[i], col, n);
    return acc;
  endfunction

  function automatic fw_res_t apply_request(fw_req_t q);
    fw_res_t r;
    int unsigned r1, c1, r2, c2;
    bit [63:0] d;
    r1 = q.r1;
    c1 = q.c1;
    r2 = q.r2;
    c2 = q.c2;
    d = {{32{q.d[31]}}, q.d};
    r.val = '0;
    r.st = ST_DONE;
    case (q.kind)
      REQ_RECT_ADD: begin
        if (r1 == 0) r1 = 1;
        if (c1 == 0) c1 = 1;
        if (r1 > r2 || c1 > c2) begin
          r.st = ST_EMPTY;
        end else if (!pool_dry) begin
          corner_update(r1, c1, d);
          corner_update(r2 + 1, c1, -d);
          corner_update(r2 + 1, c2 + 1, d);
          corner_update(r1, c2 + 1, -d);
        end
      end
      REQ_POINT_ADD: if (!pool_dry) corner_update(r1, c1, d);
      REQ_QUERY: r.val = prefix_value(r1, c1);
      default: ;
    endcase
    if (pool_dry) r.st = ST_EXHAUSTED;
    return r;
  endfunction

  task automatic send_item(fw_req_t q, bit fixed, fw_res_t want);
    fw_res_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, q.d, q.c2, q.r2, q.c1, q.r1, q.kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_request(q);
    pending_results.push_back(fixed ? want : r);
    items_sent++;
    if (q.kind == REQ_QUERY) n_queries++;
    else if (q.kind != REQ_UNUSED) n_adds++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // Let the block settle before the next register write.
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_grid(bit [10:0] g);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= g;
    grid_cfg = g;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic bit [10:0] pick_coord(int unsigned n);
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(1, n));
  endfunction

  function automatic fw_req_t random_request(int unsigned n, int unsigned rect_pct);
    fw_req_t q;
    bit [10:0] a, b;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < rect_pct) q.kind = REQ_RECT_ADD;
    else if (k < rect_pct + 15) q.kind = REQ_POINT_ADD;
    else if (k < 96) q.kind = REQ_QUERY;
    else q.kind = REQ_UNUSED;
    q.r1 = pick_coord(n);
    q.c1 = pick_coord(n);
    q.r2 = pick_coord(n);
    q.c2 = pick_coord(n);
    // Mostly well-formed rectangles; a few are left inverted.
    if ($urandom_range(0, 9) != 0) begin
      if (q.r1 > q.r2) begin a = q.r1; q.r1 = q.r2; q.r2 = a; end
      if (q.c1 > q.c2) begin b = q.c1; q.c1 = q.c2; q.c2 = b; end
    end
    q.d = $urandom();
    return q;
  endfunction

  // Directed rows against the reset grid of 1024.
  dir_row_t dir_rows[] = '{
    '{'{REQ_QUERY, 11'd1, 11'd1, 11'd0, 11'd0, 32'd0}, 1'b1, '{64'd0, ST_DONE}},
    '{'{REQ_QUERY, 11'd1024, 11'd1024, 11'd0, 11'd0, 32'd0}, 1'b1, '{64'd0, ST_DONE}},
    '{'{REQ_QUERY, 11'd0, 11'd7, 11'd0, 11'd0, 32'd0}, 1'b1, '{64'd0, ST_DONE}},
    '{'{REQ_QUERY, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 32'hFFFFFFFF}, 1'b1,
      '{64'd0, ST_DONE}},
    '{'{REQ_UNUSED, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 32'hFFFFFFFF}, 1'b1,
      '{64'd0, ST_DONE}},
    '{'{REQ_RECT_ADD, 11'd9, 11'd1, 11'd8, 11'd5, 32'd3}, 1'b1, '{64'd0, ST_EMPTY}},
    '{'{REQ_RECT_ADD, 11'd1, 11'd9, 11'd5, 11'd8, 32'd3}, 1'b1, '{64'd0, ST_EMPTY}},
    '{'{REQ_RECT_ADD, 11'd0, 11'd0, 11'd0, 11'd5, 32'd3}, 1'b1, '{64'd0, ST_EMPTY}},
    '{'{REQ_RECT_ADD, 11'd1, 11'd1, 11'd1024, 11'd1024, 32'h7FFFFFFF}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd1024, 11'd1024, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_RECT_ADD, 11'd0, 11'd0, 11'd3, 11'd3, 32'h80000000}, 1'b0, '0},
    '{'{REQ_POINT_ADD, 11'd1, 11'd1, 11'd0, 11'd0, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{REQ_POINT_ADD, 11'd1025, 11'd5, 11'd0, 11'd0, 32'd9}, 1'b0, '0},
    '{'{REQ_POINT_ADD, 11'd0, 11'd3, 11'd0, 11'd0, 32'd9}, 1'b0, '0},
    '{'{REQ_POINT_ADD, 11'd1024, 11'd1024, 11'd0, 11'd0, 32'd7}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd1, 11'd1, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd2, 11'd2, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd2047, 11'd2047, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_RECT_ADD, 11'd5, 11'd6, 11'd5, 11'd6, 32'h55555555}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd5, 11'd6, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd5, 11'd7, 11'd0, 11'd0, 32'd0}, 1'b0, '0},
    '{'{REQ_RECT_ADD, 11'd1000, 11'd1000, 11'd2047, 11'd2047, 32'hAAAAAAAA}, 1'b0, '0},
    '{'{REQ_QUERY, 11'd1024, 11'd1024, 11'd0, 11'd0, 32'd0}, 1'b0, '0}
  };

  bit [10:0] grid_plan[] = '{11'd1, 11'd2, 11'd0, 11'd37, 11'd2047, 11'd300, 11'd1024};

  initial begin
    fw_req_t q;
    int unsigned n, count, rect_pct;
    grid_cfg = 11'd1024;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
    foreach (grid_plan[p]) begin
      wait_idle();
      write_grid(grid_plan[p]);
      n = span();
      count = (p == grid_plan.size() - 1) ? 180 : 33;
      rect_pct = (p == grid_plan.size() - 1) ? 60 : 40;
      for (int unsigned k = 0; k < count; k++) begin
        if (p == grid_plan.size() - 1 && k >= count - 50) quiet = 1'b1;
        q = random_request(n, rect_pct);
        send_item(q, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d items: %0d adds, %0d queries, over seven grid sizes from 1 to 1024.",
             items_sent, n_adds, n_queries);
    $display("Saw %0d empty rectangles and %0d results after pool exhaustion; %0d mismatches.",
             n_empty, n_dry, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off so the block backs up.
  initial begin
    m_axis_tready <= 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= 260) begin
        m_axis_tready <= 1'b0;
        repeat (6000) @(negedge clk_i);
        hold_done = 1'b1;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    fw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[65:64] == ST_EMPTY) n_empty++;
      if (m_axis_tdata[65:64] == ST_EXHAUSTED) n_dry++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected item on output: %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.val || m_axis_tdata[65:64] !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected value %h status %0d, got value %h status %0d",
                     results_seen, want.val, want.st, m_axis_tdata[63:0],
                     m_axis_tdata[65:64]);
        end
      end
    end
  end

  initial begin
    #80000000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
rtl/fw2_pkg.sv
rtl/fenwick_2d_sparse_range_add.sv
tb/sv/tb_fenwick_2d_sparse_range_add.sv
